>>> hdl/mmpn_pkg.sv
// shared types and constants of the memory map page navigator
package mmpn_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int FRAME_SHIFT     = 12;
    localparam int ADDR_W          = 64;
    localparam int TYPE_W          = 4;
    localparam int COUNT_W         = 7;
    localparam int MASK_W          = 16;
    localparam int INDEX_W         = 6;
    localparam int SHIFT_W         = 6;
    localparam int CFG_DATA_W      = 16;
    localparam logic [MASK_W-1:0] USABLE_MASK_RESET = 16'd3838;

    // input item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // configuration register indexes
    localparam logic CFG_ENTRY_COUNT = 1'b0;
    localparam logic CFG_USABLE_MASK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP0,
        ST_SETUP1,
        ST_SETUP2,
        ST_SETUP3,
        ST_SCAN,
        ST_FINAL
    } state_t;

    // per-query values prepared before the table walk
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] rend;
        logic              size_nz;
        logic [ADDR_W-1:0] ps;
        logic [ADDR_W-1:0] pmask;
        logic [ADDR_W-1:0] cur;
        logic [ADDR_W-1:0] nxt;
        logic [ADDR_W-1:0] prv;
        logic              top;
        logic              bottom;
        logic [ADDR_W-1:0] lim_n;
        logic [ADDR_W-1:0] aln_n;
        logic [ADDR_W-1:0] aln_n_ps;
    } ctx_t;

    // results gathered over the table walk
    typedef struct packed {
        logic              ahit;
        logic              rhit;
        logic              found;
        logic [ADDR_W-1:0] first;
        logic              ok_n;
        logic              ok_p;
        logic [ADDR_W-1:0] best_n;
        logic [ADDR_W-1:0] best_p;
    } acc_t;

endpackage

>>> hdl/mmpn_ram.sv
// generic single write port ram with registered read
module mmpn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/mmpn_entry_unit.sv
// per-entry evaluation pipeline and result accumulation
module mmpn_entry_unit
    import mmpn_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clr,
    input  logic              rd_v,
    input  logic [TYPE_W-1:0] rd_type,
    input  logic [ADDR_W-1:0] rd_start,
    input  logic [ADDR_W-1:0] rd_frames,
    input  logic [MASK_W-1:0] usable_mask,
    input  ctx_t              ctx,
    output acc_t              acc,
    output logic              busy
);

    logic              a_v_reg;
    logic              a_use_reg, a_fz_reg;
    logic [ADDR_W-1:0] a_s_reg, a_e_reg, a_first_reg;

    logic              b_v_reg;
    logic              b_use_reg, b_nav_reg, b_ahit_reg, b_rhit_reg, b_okn_reg, b_okp_reg;
    logic              b_eltps_reg;
    logic [ADDR_W-1:0] b_s_reg, b_e_reg, b_first_reg, b_firstps_reg, b_last_reg;

    acc_t acc_reg, acc_next;

    logic [ADDR_W-1:0] a_e_c, a_first_c;
    logic              nav_ok, cn_v, cp_v, upd_n, upd_p;
    logic [ADDR_W-1:0] cn, cp;

    // stage a: end and aligned first page of the entry
    always_comb begin
        a_e_c     = rd_start + (rd_frames << FRAME_SHIFT);
        a_first_c = (rd_start + ctx.pmask) & ~ctx.pmask;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end else begin
            a_v_reg <= rd_v;
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_use_reg   <= usable_mask[rd_type];
        a_fz_reg    <= (rd_frames == '0);
        a_s_reg     <= rd_start;
        a_e_reg     <= a_e_c;
        a_first_reg <= a_first_c;
    end

    // stage b: hit tests and navigation bounds
    always_ff @(posedge aclk) begin
        b_use_reg     <= a_use_reg;
        b_nav_reg     <= a_use_reg && !a_fz_reg;
        b_ahit_reg    <= a_use_reg && (ctx.addr >= a_s_reg) && (ctx.addr < a_e_reg);
        b_rhit_reg    <= a_use_reg && ctx.size_nz && (ctx.addr >= a_s_reg)
                         && (ctx.rend <= a_e_reg);
        b_okn_reg     <= a_use_reg && !a_fz_reg && (ctx.nxt >= a_s_reg)
                         && (ctx.lim_n <= a_e_reg);
        b_okp_reg     <= a_use_reg && !a_fz_reg && (ctx.prv >= a_s_reg)
                         && (ctx.cur <= a_e_reg);
        b_eltps_reg   <= (a_e_reg < ctx.ps);
        b_s_reg       <= a_s_reg;
        b_e_reg       <= a_e_reg;
        b_first_reg   <= a_first_reg;
        b_firstps_reg <= a_first_reg + ctx.ps;
        b_last_reg    <= (a_e_reg - ctx.ps) & ~ctx.pmask;
    end

    // stage c: candidate pages and accumulation
    always_comb begin
        acc_next = acc_reg;
        nav_ok   = b_nav_reg && !b_eltps_reg && !(b_firstps_reg > b_e_reg);

        cn   = b_first_reg;
        cn_v = 1'b1;
        if (ctx.nxt <= b_first_reg) begin
            cn   = b_first_reg;
            cn_v = 1'b1;
        end else if (ctx.nxt < b_e_reg) begin
            cn   = ctx.aln_n;
            cn_v = !(ctx.aln_n_ps > b_e_reg);
        end else begin
            cn_v = 1'b0;
        end
        upd_n = nav_ok && cn_v && (cn > ctx.cur)
                && ((acc_reg.best_n == ctx.cur) || (cn < acc_reg.best_n));

        if (ctx.cur > b_last_reg) begin
            cp   = b_last_reg;
            cp_v = 1'b1;
        end else begin
            cp   = ctx.prv;
            cp_v = !(ctx.prv < b_first_reg);
        end
        upd_p = nav_ok && !(b_last_reg < b_first_reg) && !(ctx.cur <= b_first_reg)
                && cp_v && (cp < ctx.cur) && (cp > acc_reg.best_p);

        if (b_v_reg) begin
            acc_next.ahit = acc_reg.ahit | b_ahit_reg;
            acc_next.rhit = acc_reg.rhit | b_rhit_reg;
            acc_next.ok_n = acc_reg.ok_n | b_okn_reg;
            acc_next.ok_p = acc_reg.ok_p | b_okp_reg;
            if (b_use_reg && !acc_reg.found) begin
                acc_next.found = 1'b1;
                acc_next.first = b_s_reg;
            end
            if (upd_n) begin
                acc_next.best_n = cn;
            end
            if (upd_p) begin
                acc_next.best_p = cp;
            end
        end

        if (clr) begin
            acc_next        = '0;
            acc_next.best_n = ctx.cur;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc  = acc_reg;
    assign busy = a_v_reg || b_v_reg;

endmodule

>>> hdl/memory_map_page_navigator_unit.sv
// top level of the memory map page navigator
//
// Input channel (s_*): one transaction is either a load, which writes one
// descriptor into the table in the cycle it is accepted and gives no result,
// or a query, which gives exactly one result transaction on the m_* channel.
// Configuration (cfg_*): index 0 is entry_count, index 1 is usable_type_mask;
// writes are always taken and must come only while the block is idle.
// A query walks the n entries in use (n up to TABLE_DEPTH): four setup steps
// prepare the page bounds, then the table ram is walked one entry per cycle
// through a three stage evaluation pipeline, and a last step builds the result.
// s_ready is low from the query's acceptance until its result is registered.
// The result sits in an output register; the next transaction can be taken
// while it waits, and a later query holds in its last step until the
// receiver has taken the earlier result.
// Reset clears the control state, sets entry_count to 0 and the mask to its
// default; the table contents are undefined until loaded.
module memory_map_page_navigator_unit
    import mmpn_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_kind,
    input  logic [INDEX_W-1:0]    s_entry_index,
    input  logic [TYPE_W-1:0]     s_entry_type,
    input  logic [ADDR_W-1:0]     s_entry_start,
    input  logic [ADDR_W-1:0]     s_entry_frames,
    input  logic [ADDR_W-1:0]     s_query_address,
    input  logic [ADDR_W-1:0]     s_range_size,
    input  logic [SHIFT_W-1:0]    s_page_shift,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_address_hit,
    output logic                  m_range_hit,
    output logic [ADDR_W-1:0]     m_first_usable_start,
    output logic [ADDR_W-1:0]     m_next_page_address,
    output logic [ADDR_W-1:0]     m_previous_page_address,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int NW     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int WORD_W = TYPE_W + 2 * ADDR_W;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0] entry_count_reg;
    logic [MASK_W-1:0]  usable_mask_reg;

    logic [ADDR_W-1:0]  addr_reg, size_reg;
    logic [SHIFT_W-1:0] shift_reg;
    ctx_t               ctx_reg, ctx_next;

    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic               rd_v_reg;
    logic               issue;
    logic [NW-1:0]      count_ext;
    logic [CNT_W-1:0]   n_used;

    logic               out_v_reg;
    logic               out_ahit_reg, out_rhit_reg;
    logic [ADDR_W-1:0]  out_first_reg, out_next_reg, out_prev_reg;
    logic               out_load;
    logic [ADDR_W-1:0]  nxt_res, prv_res;

    logic               s_fire, ram_we, clr, eu_busy;
    logic [WORD_W-1:0]  rd_word;
    logic [AW-1:0]      ram_waddr;
    acc_t               acc;
    logic [ADDR_W-1:0]  ps_c;

    // handshakes
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign ram_we    = s_fire && (s_kind == KIND_LOAD)
                       && (32'(s_entry_index) < 32'(TABLE_DEPTH));
    assign ram_waddr = AW'(s_entry_index);

    // entries in use, limited to the table depth
    assign count_ext = NW'(entry_count_reg);
    assign n_used    = (count_ext > NW'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                      : CNT_W'(count_ext);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            usable_mask_reg <= USABLE_MASK_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ENTRY_COUNT: entry_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_USABLE_MASK: usable_mask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // descriptor table
    mmpn_ram #(
        .WIDTH(WORD_W),
        .DEPTH(TABLE_DEPTH),
        .AW   (AW)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata({s_entry_type, s_entry_start, s_entry_frames}),
        .raddr(issue_reg[AW-1:0]),
        .rdata(rd_word)
    );

    mmpn_entry_unit u_entry (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clr        (clr),
        .rd_v       (rd_v_reg),
        .rd_type    (rd_word[WORD_W-1 -: TYPE_W]),
        .rd_start   (rd_word[2*ADDR_W-1 -: ADDR_W]),
        .rd_frames  (rd_word[ADDR_W-1:0]),
        .usable_mask(usable_mask_reg),
        .ctx        (ctx_reg),
        .acc        (acc),
        .busy       (eu_busy)
    );

    // query capture
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            addr_reg  <= s_query_address;
            size_reg  <= s_range_size;
            shift_reg <= s_page_shift;
        end
        ctx_reg <= ctx_next;
    end

    // final selection of the page results
    always_comb begin
        if (n_used == '0) begin
            nxt_res = ctx_reg.addr;
        end else if (ctx_reg.top) begin
            nxt_res = ctx_reg.cur;
        end else if (acc.ok_n) begin
            nxt_res = ctx_reg.nxt;
        end else begin
            nxt_res = acc.best_n;
        end

        if ((n_used == '0) || (ctx_reg.addr == '0)) begin
            prv_res = ctx_reg.addr;
        end else if (ctx_reg.bottom) begin
            prv_res = ctx_reg.cur;
        end else if (acc.ok_p) begin
            prv_res = ctx_reg.prv;
        end else if (acc.best_p != '0) begin
            prv_res = acc.best_p;
        end else begin
            prv_res = ctx_reg.cur;
        end
    end

    // state register and walk counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            issue_reg <= '0;
            rd_v_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            issue_reg <= issue_next;
            rd_v_reg  <= issue;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        ctx_next   = ctx_reg;
        issue_next = issue_reg;
        issue      = 1'b0;
        clr        = 1'b0;
        out_load   = 1'b0;
        ps_c       = ADDR_W'(1) << shift_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_kind == KIND_QUERY)) begin
                    state_next = ST_SETUP0;
                end
            end
            ST_SETUP0: begin
                ctx_next.addr    = addr_reg;
                ctx_next.rend    = addr_reg + size_reg;
                ctx_next.size_nz = (size_reg != '0);
                ctx_next.ps      = ps_c;
                ctx_next.pmask   = ~({ADDR_W{1'b1}} << shift_reg);
                ctx_next.cur     = addr_reg & ({ADDR_W{1'b1}} << shift_reg);
                state_next       = ST_SETUP1;
            end
            ST_SETUP1: begin
                {ctx_next.top, ctx_next.nxt} = {1'b0, ctx_reg.cur} + {1'b0, ctx_reg.ps};
                ctx_next.prv    = ctx_reg.cur - ctx_reg.ps;
                ctx_next.bottom = (ctx_reg.cur < ctx_reg.ps);
                state_next      = ST_SETUP2;
            end
            ST_SETUP2: begin
                ctx_next.aln_n = (ctx_reg.nxt + ctx_reg.pmask) & ~ctx_reg.pmask;
                ctx_next.lim_n = ctx_reg.nxt + ctx_reg.ps;
                state_next     = ST_SETUP3;
            end
            ST_SETUP3: begin
                ctx_next.aln_n_ps = ctx_reg.aln_n + ctx_reg.ps;
                clr        = 1'b1;
                issue_next = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (issue_reg < n_used) begin
                    issue      = 1'b1;
                    issue_next = issue_reg + 1'b1;
                end else if (!rd_v_reg && !eu_busy) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (!out_v_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (out_load) begin
            out_v_reg <= 1'b1;
        end else if (m_ready) begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_ahit_reg  <= acc.ahit;
            out_rhit_reg  <= acc.rhit;
            out_first_reg <= acc.found ? acc.first : '0;
            out_next_reg  <= nxt_res;
            out_prev_reg  <= prv_res;
        end
    end

    assign m_valid                 = out_v_reg;
    assign m_address_hit           = out_ahit_reg;
    assign m_range_hit             = out_rhit_reg;
    assign m_first_usable_start    = out_first_reg;
    assign m_next_page_address     = out_next_reg;
    assign m_previous_page_address = out_prev_reg;

`ifndef SYNTHESIS
    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_IDLE))
        else $error("table written outside idle");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (issue_reg <= n_used))
        else $error("walk ran past the entries in use");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_FINAL))
        else $error("result raised outside the last step");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_v_reg) |-> m_ready)
        else $error("pending result overwritten");
`endif

endmodule
